[rtl/cpt_pkg.sv]
// shared types and constants for the closest-point-on-triangle datapath
`timescale 1ns / 1ps

package cpt_pkg;

    // partial product digit widths for the split multipliers
    localparam int MUL_CHUNK  = 18;
    localparam int WIDE_CHUNK = 31;

    // voronoi region of the query point, in test order
    typedef enum logic [2:0]
    {
        RG_A    = 3'd0,
        RG_B    = 3'd1,
        RG_EAB  = 3'd2,
        RG_C    = 3'd3,
        RG_EAC  = 3'd4,
        RG_EBC  = 3'd5,
        RG_FACE = 3'd6
    } region_t;

endpackage

[rtl/cpt_delay.sv]
// enabled delay line for payload carried alongside the datapath
`timescale 1ns / 1ps

module cpt_delay
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= d;
            for (int k = 1; k < DEPTH; k++)
            begin
                line_reg[k] <= line_reg[k-1];
            end
        end
    end

    assign q = line_reg[DEPTH-1];

endmodule

[rtl/cpt_smul.sv]
// two-stage signed multiplier, b split into digits with registered partial products
`timescale 1ns / 1ps

module cpt_smul
    import cpt_pkg::*;
#(
    parameter int A_WIDTH = 16,
    parameter int B_WIDTH = 16,
    parameter int CHUNK   = MUL_CHUNK
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [A_WIDTH-1:0]         a,
    input  logic signed [B_WIDTH-1:0]         b,
    output logic signed [A_WIDTH+B_WIDTH-1:0] p
);

    localparam int NC  = (B_WIDTH + CHUNK - 1) / CHUNK;
    localparam int EB  = NC * CHUNK;
    localparam int PPW = A_WIDTH + CHUNK + 1;
    localparam int PW  = A_WIDTH + B_WIDTH;

    logic signed [EB-1:0]  b_ext;
    logic signed [PPW-1:0] pp_reg [NC];
    logic signed [PW-1:0]  p_reg;
    logic signed [PW-1:0]  p_next;

    assign b_ext = EB'(b);

    for (genvar k = 0; k < NC; k++)
    begin : g_pp
        if (k == NC - 1)
        begin : g_top
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pp_reg[k] <= PPW'(a) * PPW'($signed(b_ext[k*CHUNK +: CHUNK]));
                end
            end
        end
        else
        begin : g_low
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pp_reg[k] <= PPW'(a) * PPW'($signed({1'b0, b_ext[k*CHUNK +: CHUNK]}));
                end
            end
        end
    end

    always_comb
    begin
        p_next = '0;
        for (int k = 0; k < NC; k++)
        begin
            p_next = p_next + (PW'(pp_reg[k]) <<< (k * CHUNK));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

[rtl/cpt_div.sv]
// pipelined restoring divider, (num << FRAC) / den truncated toward zero, one bit a stage
`timescale 1ns / 1ps

module cpt_div
#(
    parameter int NUM_WIDTH = 16,
    parameter int DEN_WIDTH = 16,
    parameter int FRAC      = 8
)
(
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [NUM_WIDTH-1:0]      num,
    input  logic signed [DEN_WIDTH-1:0]      den,
    output logic signed [NUM_WIDTH+FRAC:0]   quo
);

    localparam int NW = NUM_WIDTH + FRAC;
    localparam int QW = NW + 1;

    logic [NUM_WIDTH-1:0] num_mag;
    logic [DEN_WIDTH-1:0] den_mag;
    logic [NW-1:0]        dvd_reg [NW+1];
    logic [DEN_WIDTH-1:0] rem_reg [NW+1];
    logic [DEN_WIDTH-1:0] dsr_reg [NW+1];
    logic                 neg_reg [NW+1];
    logic signed [QW-1:0] mag_s;
    logic signed [QW-1:0] quo_reg;

    assign num_mag = num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
    assign den_mag = den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : DEN_WIDTH'(den);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= num[NUM_WIDTH-1] ^ den[DEN_WIDTH-1];
            dvd_reg[0] <= {num_mag, {FRAC{1'b0}}};
            rem_reg[0] <= '0;
            dsr_reg[0] <= den_mag;
        end
    end

    for (genvar i = 1; i <= NW; i++)
    begin : g_step
        logic [DEN_WIDTH:0] trial;
        logic [DEN_WIDTH:0] diff;
        logic               take;

        assign trial = {rem_reg[i-1], dvd_reg[i-1][NW-1]};
        assign diff  = trial - {1'b0, dsr_reg[i-1]};
        assign take  = !diff[DEN_WIDTH];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
                dvd_reg[i] <= {dvd_reg[i-1][NW-2:0], take};
                dsr_reg[i] <= dsr_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    assign mag_s = {1'b0, dvd_reg[NW]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[NW] ? -mag_s : mag_s;
        end
    end

    assign quo = quo_reg;

endmodule

[rtl/closest_point_on_triangle.sv]
// closest point on a triangle to a query point, signed fixed point, fully pipelined
// throughput: one item per cycle while the output queue is not full
// depth is set by the ratio dividers, one quotient bit a stage
// a full two-entry output queue stalls the whole pipeline, nothing is dropped
// reset clears the valid bits and the output queue; datapath registers are not reset
`timescale 1ns / 1ps

module closest_point_on_triangle
    import cpt_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic signed [COORD_WIDTH-1:0] vert_a_x,
    input  logic signed [COORD_WIDTH-1:0] vert_a_y,
    input  logic signed [COORD_WIDTH-1:0] vert_a_z,
    input  logic signed [COORD_WIDTH-1:0] vert_b_x,
    input  logic signed [COORD_WIDTH-1:0] vert_b_y,
    input  logic signed [COORD_WIDTH-1:0] vert_b_z,
    input  logic signed [COORD_WIDTH-1:0] vert_c_x,
    input  logic signed [COORD_WIDTH-1:0] vert_c_y,
    input  logic signed [COORD_WIDTH-1:0] vert_c_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] near_x,
    output logic signed [COORD_WIDTH-1:0] near_y,
    output logic signed [COORD_WIDTH-1:0] near_z
);

    localparam int W       = COORD_WIDTH;
    localparam int F       = FRAC_BITS;
    localparam int EW      = W + 1;
    localparam int PW      = 2 * EW;
    localparam int DSUM    = PW + 2;
    localparam int DW      = DSUM - F;
    localparam int DE      = DW + 1;
    localparam int DB      = DW + 2;
    localparam int PV      = 2 * DW;
    localparam int VW      = PV + 1;
    localparam int SW      = VW + 2;
    localparam int NW      = VW + F;
    localparam int QW      = NW + 1;
    localparam int FPW     = EW + QW;
    localparam int FSW     = FPW + 1;
    localparam int TW      = FSW - F + 1;
    localparam int DIV_LAT = NW + 2;
    localparam int LAST    = 9 + DIV_LAT + 5;

    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    localparam int MA_IDX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int MB_IDX [6] = '{3, 1, 1, 5, 5, 3};

    logic            adv;
    logic [LAST-1:0] vld_reg;

    // stage 1: captured coordinates
    logic signed [W-1:0] p1_reg [3];
    logic signed [W-1:0] a1_reg [3];
    logic signed [W-1:0] b1_reg [3];
    logic signed [W-1:0] c1_reg [3];

    // stage 2: edge and offset vectors
    logic signed [EW-1:0] ab2_reg [3];
    logic signed [EW-1:0] ac2_reg [3];
    logic signed [EW-1:0] ap2_reg [3];
    logic signed [EW-1:0] bp2_reg [3];
    logic signed [EW-1:0] cp2_reg [3];
    logic signed [EW-1:0] bc2_reg [3];

    // stages 3 and 4: dot products
    logic signed [EW-1:0]   dot_u [18];
    logic signed [EW-1:0]   dot_v [18];
    logic signed [PW-1:0]   prod3_reg [18];
    logic signed [DSUM-1:0] dsum [6];
    logic signed [DW-1:0]   d4_reg [6];
    logic [6*DW-1:0]        d4_f;

    // stages 5 to 8: area terms
    logic signed [PV-1:0] pv [6];
    logic signed [VW-1:0] va7_reg;
    logic signed [VW-1:0] vb7_reg;
    logic signed [VW-1:0] vc7_reg;
    logic signed [VW-1:0] va8_reg;
    logic signed [VW-1:0] vb8_reg;
    logic signed [VW-1:0] vc8_reg;
    logic signed [SW-1:0] s8_reg;

    // payload carried to the region stage
    logic [9*W-1:0]  abc1_f;
    logic [9*W-1:0]  abc8_f;
    logic [9*EW-1:0] edge2_f;
    logic [9*EW-1:0] edge8_f;
    logic [6*DW-1:0] d8_f;
    logic [3*W-1:0]  a8_f;
    logic [3*W-1:0]  b8_f;
    logic [3*W-1:0]  c8_f;
    logic [3*EW-1:0] ab8_f;
    logic [3*EW-1:0] ac8_f;
    logic [3*EW-1:0] bc8_f;
    logic signed [DW-1:0] d8 [6];

    // stage 9: region decision and operand select
    logic signed [DE-1:0] n_bc;
    logic signed [DE-1:0] m_bc;
    logic signed [DE-1:0] den_ab;
    logic signed [DE-1:0] den_ac;
    logic signed [DB-1:0] den_bc;
    region_t              region;

    logic signed [VW-1:0] num1_next;
    logic signed [VW-1:0] num2_next;
    logic signed [SW-1:0] den1_next;
    logic signed [SW-1:0] den2_next;
    logic [3*W-1:0]       base_next;
    logic [3*EW-1:0]      dir1_next;
    logic [3*EW-1:0]      dir2_next;
    logic signed [VW-1:0] num1_reg;
    logic signed [VW-1:0] num2_reg;
    logic signed [SW-1:0] den1_reg;
    logic signed [SW-1:0] den2_reg;
    logic [3*W-1:0]       base9_reg;
    logic [6*EW-1:0]      dir9_f;

    // ratios and weighted sum
    logic signed [QW-1:0] q1;
    logic signed [QW-1:0] q2;
    logic [6*EW-1:0]      dir_q_f;
    logic [3*W-1:0]       base_q_f;
    logic signed [EW-1:0] dir1_q [3];
    logic signed [EW-1:0] dir2_q [3];
    logic signed [W-1:0]  base_q [3];
    logic signed [FPW-1:0] pr1 [3];
    logic signed [FPW-1:0] pr2 [3];
    logic signed [FSW-1:0] sum_reg [3];
    logic signed [TW-1:0]  t_reg [3];
    logic signed [W-1:0]   sat_reg [3];

    // output queue
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic [3*W-1:0] slot0_reg;
    logic [3*W-1:0] slot0_next;
    logic [3*W-1:0] slot1_reg;
    logic [3*W-1:0] slot1_next;
    logic [3*W-1:0] res_f;
    logic           push;
    logic           pop;

    assign adv      = (cnt_reg != 2'd2);
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-2:0], in_valid};
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg[0] <= point_x;
            p1_reg[1] <= point_y;
            p1_reg[2] <= point_z;
            a1_reg[0] <= vert_a_x;
            a1_reg[1] <= vert_a_y;
            a1_reg[2] <= vert_a_z;
            b1_reg[0] <= vert_b_x;
            b1_reg[1] <= vert_b_y;
            b1_reg[2] <= vert_b_z;
            c1_reg[0] <= vert_c_x;
            c1_reg[1] <= vert_c_y;
            c1_reg[2] <= vert_c_z;
        end
    end

    // stage 2
    for (genvar i = 0; i < 3; i++)
    begin : g_diff
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ab2_reg[i] <= EW'(b1_reg[i]) - EW'(a1_reg[i]);
                ac2_reg[i] <= EW'(c1_reg[i]) - EW'(a1_reg[i]);
                ap2_reg[i] <= EW'(p1_reg[i]) - EW'(a1_reg[i]);
                bp2_reg[i] <= EW'(p1_reg[i]) - EW'(b1_reg[i]);
                cp2_reg[i] <= EW'(p1_reg[i]) - EW'(c1_reg[i]);
                bc2_reg[i] <= EW'(c1_reg[i]) - EW'(b1_reg[i]);
            end
        end
    end

    // stage 3: d1..d6 use (ab|ac) against (ap|bp|cp)
    for (genvar k = 0; k < 6; k++)
    begin : g_dot
        for (genvar i = 0; i < 3; i++)
        begin : g_term
            assign dot_u[k*3+i] = (k % 2 == 0) ? ab2_reg[i] : ac2_reg[i];
            assign dot_v[k*3+i] = (k / 2 == 0) ? ap2_reg[i] :
                                  (k / 2 == 1) ? bp2_reg[i] : cp2_reg[i];

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod3_reg[k*3+i] <= PW'(dot_u[k*3+i]) * PW'(dot_v[k*3+i]);
                end
            end
        end

        // stage 4
        assign dsum[k] = DSUM'(prod3_reg[k*3]) + DSUM'(prod3_reg[k*3+1])
                       + DSUM'(prod3_reg[k*3+2]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d4_reg[k] <= DW'(dsum[k] >>> F);
            end
        end

        assign d4_f[k*DW +: DW] = d4_reg[k];
    end

    // stages 5 and 6: d products for the area terms
    for (genvar k = 0; k < 6; k++)
    begin : g_area
        cpt_smul
        #(
            .A_WIDTH (DW),
            .B_WIDTH (DW),
            .CHUNK   (MUL_CHUNK)
        )
        u_mul
        (
            .clk (clk),
            .en  (adv),
            .a   (d4_reg[MA_IDX[k]]),
            .b   (d4_reg[MB_IDX[k]]),
            .p   (pv[k])
        );
    end

    // stages 7 and 8
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vc7_reg <= VW'(pv[0]) - VW'(pv[1]);
            vb7_reg <= VW'(pv[2]) - VW'(pv[3]);
            va7_reg <= VW'(pv[4]) - VW'(pv[5]);
            va8_reg <= va7_reg;
            vb8_reg <= vb7_reg;
            vc8_reg <= vc7_reg;
            s8_reg  <= SW'(va7_reg) + SW'(vb7_reg) + SW'(vc7_reg);
        end
    end

    assign abc1_f  = {c1_reg[2], c1_reg[1], c1_reg[0],
                      b1_reg[2], b1_reg[1], b1_reg[0],
                      a1_reg[2], a1_reg[1], a1_reg[0]};
    assign edge2_f = {bc2_reg[2], bc2_reg[1], bc2_reg[0],
                      ac2_reg[2], ac2_reg[1], ac2_reg[0],
                      ab2_reg[2], ab2_reg[1], ab2_reg[0]};

    cpt_delay #(.WIDTH (9*W), .DEPTH (7)) u_vert_line
    (
        .clk (clk),
        .en  (adv),
        .d   (abc1_f),
        .q   (abc8_f)
    );

    cpt_delay #(.WIDTH (9*EW), .DEPTH (6)) u_edge_line
    (
        .clk (clk),
        .en  (adv),
        .d   (edge2_f),
        .q   (edge8_f)
    );

    cpt_delay #(.WIDTH (6*DW), .DEPTH (4)) u_dot_line
    (
        .clk (clk),
        .en  (adv),
        .d   (d4_f),
        .q   (d8_f)
    );

    assign a8_f  = abc8_f[0 +: 3*W];
    assign b8_f  = abc8_f[3*W +: 3*W];
    assign c8_f  = abc8_f[6*W +: 3*W];
    assign ab8_f = edge8_f[0 +: 3*EW];
    assign ac8_f = edge8_f[3*EW +: 3*EW];
    assign bc8_f = edge8_f[6*EW +: 3*EW];

    for (genvar k = 0; k < 6; k++)
    begin : g_d8
        assign d8[k] = d8_f[k*DW +: DW];
    end

    // stage 9
    assign n_bc   = DE'(d8[3]) - DE'(d8[2]);
    assign m_bc   = DE'(d8[4]) - DE'(d8[5]);
    assign den_ab = DE'(d8[0]) - DE'(d8[2]);
    assign den_ac = DE'(d8[1]) - DE'(d8[5]);
    assign den_bc = DB'(n_bc) + DB'(m_bc);

    always_comb
    begin
        if ((d8[0][DW-1] || d8[0] == '0) && (d8[1][DW-1] || d8[1] == '0))
        begin
            region = RG_A;
        end
        else if (!d8[2][DW-1] && (n_bc[DE-1] || n_bc == '0))
        begin
            region = RG_B;
        end
        else if ((vc8_reg[VW-1] || vc8_reg == '0) && !d8[0][DW-1]
                 && (d8[2][DW-1] || d8[2] == '0))
        begin
            region = RG_EAB;
        end
        else if (!d8[5][DW-1] && (m_bc[DE-1] || m_bc == '0))
        begin
            region = RG_C;
        end
        else if ((vb8_reg[VW-1] || vb8_reg == '0) && !d8[1][DW-1]
                 && (d8[5][DW-1] || d8[5] == '0))
        begin
            region = RG_EAC;
        end
        else if ((va8_reg[VW-1] || va8_reg == '0) && !n_bc[DE-1] && !m_bc[DE-1])
        begin
            region = RG_EBC;
        end
        else
        begin
            region = RG_FACE;
        end
    end

    // vertex results and degenerate divisors fall back to a plain point with zero directions
    always_comb
    begin
        num1_next = '0;
        num2_next = '0;
        den1_next = SW'(1);
        den2_next = SW'(1);
        base_next = a8_f;
        dir1_next = '0;
        dir2_next = '0;
        unique case (region)
            RG_A:
            begin
                base_next = a8_f;
            end
            RG_B:
            begin
                base_next = b8_f;
            end
            RG_C:
            begin
                base_next = c8_f;
            end
            RG_EAB:
            begin
                if (den_ab != '0)
                begin
                    num1_next = VW'(d8[0]);
                    den1_next = SW'(den_ab);
                    dir1_next = ab8_f;
                end
            end
            RG_EAC:
            begin
                if (den_ac != '0)
                begin
                    num1_next = VW'(d8[1]);
                    den1_next = SW'(den_ac);
                    dir1_next = ac8_f;
                end
            end
            RG_EBC:
            begin
                if (den_bc != '0)
                begin
                    base_next = b8_f;
                    num1_next = VW'(n_bc);
                    den1_next = SW'(den_bc);
                    dir1_next = bc8_f;
                end
            end
            RG_FACE:
            begin
                if (s8_reg != '0)
                begin
                    num1_next = vb8_reg;
                    den1_next = s8_reg;
                    num2_next = vc8_reg;
                    den2_next = s8_reg;
                    dir1_next = ab8_f;
                    dir2_next = ac8_f;
                end
            end
            default:
            begin
                base_next = a8_f;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num1_reg  <= num1_next;
            num2_reg  <= num2_next;
            den1_reg  <= den1_next;
            den2_reg  <= den2_next;
            base9_reg <= base_next;
            dir9_f    <= {dir2_next, dir1_next};
        end
    end

    // ratio dividers
    cpt_div #(.NUM_WIDTH (VW), .DEN_WIDTH (SW), .FRAC (F)) u_div1
    (
        .clk (clk),
        .en  (adv),
        .num (num1_reg),
        .den (den1_reg),
        .quo (q1)
    );

    cpt_div #(.NUM_WIDTH (VW), .DEN_WIDTH (SW), .FRAC (F)) u_div2
    (
        .clk (clk),
        .en  (adv),
        .num (num2_reg),
        .den (den2_reg),
        .quo (q2)
    );

    cpt_delay #(.WIDTH (6*EW), .DEPTH (DIV_LAT)) u_dir_line
    (
        .clk (clk),
        .en  (adv),
        .d   (dir9_f),
        .q   (dir_q_f)
    );

    cpt_delay #(.WIDTH (3*W), .DEPTH (DIV_LAT + 3)) u_base_line
    (
        .clk (clk),
        .en  (adv),
        .d   (base9_reg),
        .q   (base_q_f)
    );

    // weighted directions, floor shift, base add and saturation
    for (genvar i = 0; i < 3; i++)
    begin : g_out
        assign dir1_q[i] = dir_q_f[i*EW +: EW];
        assign dir2_q[i] = dir_q_f[(3+i)*EW +: EW];
        assign base_q[i] = base_q_f[i*W +: W];

        cpt_smul
        #(
            .A_WIDTH (EW),
            .B_WIDTH (QW),
            .CHUNK   (WIDE_CHUNK)
        )
        u_mul1
        (
            .clk (clk),
            .en  (adv),
            .a   (dir1_q[i]),
            .b   (q1),
            .p   (pr1[i])
        );

        cpt_smul
        #(
            .A_WIDTH (EW),
            .B_WIDTH (QW),
            .CHUNK   (WIDE_CHUNK)
        )
        u_mul2
        (
            .clk (clk),
            .en  (adv),
            .a   (dir2_q[i]),
            .b   (q2),
            .p   (pr2[i])
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sum_reg[i] <= FSW'(pr1[i]) + FSW'(pr2[i]);
                t_reg[i]   <= TW'(sum_reg[i] >>> F) + TW'(base_q[i]);
                if (&t_reg[i][TW-1:W-1] || ~|t_reg[i][TW-1:W-1])
                begin
                    sat_reg[i] <= t_reg[i][W-1:0];
                end
                else if (t_reg[i][TW-1])
                begin
                    sat_reg[i] <= SAT_MIN;
                end
                else
                begin
                    sat_reg[i] <= SAT_MAX;
                end
            end
        end
    end

    // two-entry output queue
    assign res_f = {sat_reg[2], sat_reg[1], sat_reg[0]};
    assign push  = adv && vld_reg[LAST-1];
    assign pop   = out_valid && out_ready;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (push && pop)
        begin
            slot0_next = res_f;
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
            begin
                slot0_next = res_f;
            end
            else
            begin
                slot1_next = res_f;
            end
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign near_x    = slot0_reg[0 +: W];
    assign near_y    = slot0_reg[W +: W];
    assign near_z    = slot0_reg[2*W +: W];

endmodule
